### src/sacache_pkg.sv
// ----------------------------------------------------------------------------
// sacache_pkg
// Shared types and constants of the cache tag and replacement engine.
// ----------------------------------------------------------------------------
package sacache_pkg;

  localparam int unsigned TAG_W   = 48;
  localparam int unsigned STAMP_W = 48;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned ENT_W   = 1 + TAG_W + STAMP_W;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAY_BITS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_LRU     = 2'd3;

  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic             mem_read;
    logic             mem_write;
    logic [CNT_W-1:0] read_total;
    logic [CNT_W-1:0] write_total;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
  } rsp_t;

  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic [4:0] offset_bits;
    logic [3:0] set_bits;
    logic [2:0] way_bits;
    logic       use_lru;
  } cfg_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic rd;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic rd_last;
  } ctrl_sts_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_e;

endpackage

### src/set_assoc_cache_tag_lru_fifo_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lru_fifo_unit
// Tag and replacement engine of a write-through, write-allocate cache.
// ----------------------------------------------------------------------------
// After reset the tag store is swept once to clear its valid bits, with busy_o
// high. Configuration writes are taken only while the unit is idle and no
// access is being started (cfg_ready_o low otherwise). An access is accepted
// when start_i is high and busy_o is low. The ways of the selected set are
// then read one per cycle from the tag store, which has one read port and one
// write port (way count clamped to MAX_WAYS): an access passes through the
// accept cycle, the way scan, a drain state and a commit state. Its result
// appears on rsp_o with a one-cycle done_o strobe in the first cycle that
// busy_o is low again, and the next access may be accepted in that same
// cycle. The result is held only until the next access commits: sample it
// on the done_o cycle.
module set_assoc_cache_tag_lru_fifo_unit #(
  parameter int unsigned MAX_SETS  = 256,
  parameter int unsigned MAX_WAYS  = 16,
  parameter int unsigned ADDR_BITS = 48
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sacache_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sacache_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                               start_i,
  output logic                               busy_o,
  input  sacache_pkg::req_t                  req_i,
  output logic                               done_o,
  output sacache_pkg::rsp_t                  rsp_o
);

  sacache_pkg::ctrl_cmd_t cmd;
  sacache_pkg::ctrl_sts_t sts;

  // hold configuration off while a transaction is in flight or starting
  assign cfg_ready_o = !busy_o && !start_i;

  sacache_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  sacache_dp #(
    .MAX_SETS  (MAX_SETS),
    .MAX_WAYS  (MAX_WAYS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

endmodule

### src/sacache_ram.sv
// ----------------------------------------------------------------------------
// sacache_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sacache_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/sacache_ctrl.sv
// ----------------------------------------------------------------------------
// sacache_ctrl
// Sequencer: clearing pass after reset, then load, way scan, drain, commit.
// ----------------------------------------------------------------------------
module sacache_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  sacache_pkg::ctrl_sts_t sts_i,
  output sacache_pkg::ctrl_cmd_t cmd_o,
  output logic                   busy_o
);

  sacache_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sacache_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sacache_pkg::ST_CLEAR: begin
        if (sts_i.clr_last) state_d = sacache_pkg::ST_IDLE;
      end
      sacache_pkg::ST_IDLE: begin
        if (start_i) state_d = sacache_pkg::ST_SCAN;
      end
      sacache_pkg::ST_SCAN: begin
        if (sts_i.rd_last) state_d = sacache_pkg::ST_DRAIN;
      end
      sacache_pkg::ST_DRAIN:  state_d = sacache_pkg::ST_COMMIT;
      sacache_pkg::ST_COMMIT: state_d = sacache_pkg::ST_IDLE;
      default:                state_d = sacache_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      sacache_pkg::ST_CLEAR:  cmd_o.clr = 1'b1;
      sacache_pkg::ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      sacache_pkg::ST_SCAN:   cmd_o.rd = 1'b1;
      sacache_pkg::ST_DRAIN:  cmd_o = '0;
      sacache_pkg::ST_COMMIT: cmd_o.commit = 1'b1;
      default:                cmd_o = '0;
    endcase
  end

endmodule

### src/sacache_dp.sv
// ----------------------------------------------------------------------------
// sacache_dp
// Datapath: configuration, address split, way scan, victim choice, counters.
// ----------------------------------------------------------------------------
module sacache_dp #(
  parameter int unsigned MAX_SETS  = 256,
  parameter int unsigned MAX_WAYS  = 16,
  parameter int unsigned ADDR_BITS = 48
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_valid_i,
  input  logic [sacache_pkg::CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [sacache_pkg::CFG_DATA_W-1:0]          cfg_data_i,
  input  sacache_pkg::req_t                           req_i,
  input  sacache_pkg::ctrl_cmd_t                      cmd_i,
  output sacache_pkg::ctrl_sts_t                      sts_o,
  output logic                                        done_o,
  output sacache_pkg::rsp_t                           rsp_o
);

  localparam int unsigned DEPTH   = MAX_SETS * MAX_WAYS;
  localparam int unsigned IDX_W   = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int unsigned SET_IW  = MAX_SETS > 1 ? $clog2(MAX_SETS) : 1;
  localparam int unsigned WAY_IW  = MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned SET_LOG = $clog2(MAX_SETS + 1) - 1;
  localparam int unsigned WAY_LOG = $clog2(MAX_WAYS + 1) - 1;
  localparam int unsigned AW_EFF  = ADDR_BITS < sacache_pkg::ADDR_W ? ADDR_BITS
                                                                    : sacache_pkg::ADDR_W;
  localparam logic [sacache_pkg::ADDR_W-1:0] ADDR_MASK =
    sacache_pkg::ADDR_W'((65'd1 << AW_EFF) - 65'd1);

  sacache_pkg::cfg_t cfg_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset_bits <= 5'd4;
      cfg_q.set_bits    <= 4'd0;
      cfg_q.way_bits    <= 3'd0;
      cfg_q.use_lru     <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sacache_pkg::CFG_OFFSET_BITS: cfg_q.offset_bits <= cfg_data_i[4:0];
        sacache_pkg::CFG_SET_BITS:    cfg_q.set_bits    <= cfg_data_i[3:0];
        sacache_pkg::CFG_WAY_BITS:    cfg_q.way_bits    <= cfg_data_i[2:0];
        sacache_pkg::CFG_USE_LRU:     cfg_q.use_lru     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [3:0] sb;
  logic [2:0] wb;
  logic [5:0] shamt;
  logic [sacache_pkg::ADDR_W-1:0] addr_m;
  logic [sacache_pkg::ADDR_W-1:0] set_full;
  logic [sacache_pkg::TAG_W-1:0]  tag_new;
  logic [SET_IW-1:0]              set_new;
  logic [WAY_IW-1:0]              way_last;

  // clamp geometry to what the store holds
  assign sb = (32'(cfg_q.set_bits) > SET_LOG) ? 4'(SET_LOG) : cfg_q.set_bits;
  assign wb = (32'(cfg_q.way_bits) > WAY_LOG) ? 3'(WAY_LOG) : cfg_q.way_bits;
  assign shamt    = 6'(cfg_q.offset_bits) + 6'(sb);
  assign addr_m   = req_i.address & ADDR_MASK;
  assign set_full = (addr_m >> cfg_q.offset_bits) &
                    sacache_pkg::ADDR_W'((20'd1 << sb) - 20'd1);
  assign set_new  = SET_IW'(set_full);
  assign tag_new  = (32'(shamt) >= ADDR_BITS) ? '0 : (addr_m >> shamt);
  assign way_last = WAY_IW'((32'd1 << wb) - 32'd1);

  logic                           req_type_q;
  logic [sacache_pkg::TAG_W-1:0]  tag_q;
  logic [SET_IW-1:0]              set_q;
  logic [sacache_pkg::STAMP_W-1:0] clock_q;
  logic [WAY_IW-1:0]              rd_way_q;
  logic [WAY_IW-1:0]              ev_way_q;
  logic                           eval_q;
  logic                           hit_q;
  logic                           empty_q;
  logic [WAY_IW-1:0]              hit_way_q;
  logic [WAY_IW-1:0]              empty_way_q;
  logic [WAY_IW-1:0]              vic_way_q;
  logic [sacache_pkg::STAMP_W-1:0] min_q;
  logic [IDX_W-1:0]               clr_q;
  logic [sacache_pkg::CNT_W-1:0]  read_cnt_q, write_cnt_q, hit_cnt_q, miss_cnt_q;
  logic                           done_q;
  logic                           res_hit_q, res_wr_q;

  logic                           ram_we;
  logic [IDX_W-1:0]               ram_waddr, ram_raddr;
  sacache_pkg::entry_t            ram_wdata, ram_rdata;
  logic [WAY_IW-1:0]              slot_way;
  logic [IDX_W-1:0]               set_base;

  assign set_base = IDX_W'(set_q) * IDX_W'(MAX_WAYS);
  assign slot_way = hit_q ? hit_way_q : (empty_q ? empty_way_q : vic_way_q);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = set_base + IDX_W'(slot_way);
    ram_wdata = '{valid: 1'b1, tag: tag_q, stamp: clock_q};
    if (cmd_i.clr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (cmd_i.commit) begin
      ram_we = !hit_q || cfg_q.use_lru;
    end
  end

  assign ram_raddr = set_base + IDX_W'(rd_way_q);

  sacache_ram #(
    .WIDTH (sacache_pkg::ENT_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign sts_o.clr_last = (clr_q == IDX_W'(DEPTH - 1));
  assign sts_o.rd_last  = (rd_way_q == way_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      clock_q     <= '0;
      read_cnt_q  <= '0;
      write_cnt_q <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      done_q      <= 1'b0;
      eval_q      <= 1'b0;
      rd_way_q    <= '0;
    end else begin
      done_q <= cmd_i.commit;
      eval_q <= cmd_i.rd;
      if (cmd_i.clr) clr_q <= clr_q + IDX_W'(1);
      if (cmd_i.load) begin
        rd_way_q <= '0;
        if (clock_q != sacache_pkg::STAMP_MAX) clock_q <= clock_q + 1'b1;
      end else if (cmd_i.rd) begin
        rd_way_q <= rd_way_q + WAY_IW'(1);
      end
      if (cmd_i.commit) begin
        if (hit_q) begin
          if (hit_cnt_q != sacache_pkg::CNT_MAX) hit_cnt_q <= hit_cnt_q + 1'b1;
        end else begin
          if (miss_cnt_q != sacache_pkg::CNT_MAX) miss_cnt_q <= miss_cnt_q + 1'b1;
          if (read_cnt_q != sacache_pkg::CNT_MAX) read_cnt_q <= read_cnt_q + 1'b1;
        end
        if (req_type_q && write_cnt_q != sacache_pkg::CNT_MAX) begin
          write_cnt_q <= write_cnt_q + 1'b1;
        end
      end
    end
  end

  // per-access payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_type_q <= req_i.req_type;
      tag_q      <= tag_new;
      set_q      <= set_new;
      hit_q      <= 1'b0;
      empty_q    <= 1'b0;
    end
    if (cmd_i.rd) ev_way_q <= rd_way_q;
    if (eval_q) begin
      if (ram_rdata.valid && ram_rdata.tag == tag_q && !hit_q) begin
        hit_q     <= 1'b1;
        hit_way_q <= ev_way_q;
      end
      if (!ram_rdata.valid && !empty_q) begin
        empty_q     <= 1'b1;
        empty_way_q <= ev_way_q;
      end
      // strict compare keeps the lowest way on a tie
      if (ev_way_q == '0 || ram_rdata.stamp < min_q) begin
        min_q     <= ram_rdata.stamp;
        vic_way_q <= ev_way_q;
      end
    end
    if (cmd_i.commit) begin
      res_hit_q <= hit_q;
      res_wr_q  <= req_type_q;
    end
  end

  assign done_o            = done_q;
  assign rsp_o.hit         = res_hit_q;
  assign rsp_o.mem_read    = !res_hit_q;
  assign rsp_o.mem_write   = res_wr_q;
  assign rsp_o.read_total  = read_cnt_q;
  assign rsp_o.write_total = write_cnt_q;
  assign rsp_o.hit_total   = hit_cnt_q;
  assign rsp_o.miss_total  = miss_cnt_q;

  a_no_wr_during_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && (cmd_i.rd || eval_q)))
    else $error("store written while a set scan is in flight");

  a_read_cnt_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_cnt_q >= $past(read_cnt_q))
    else $error("read count went backward");

  a_clock_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clock_q >= $past(clock_q))
    else $error("access clock went backward");

  a_one_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> (hit_cnt_q != $past(hit_cnt_q)) + (miss_cnt_q != $past(miss_cnt_q)) <= 1)
    else $error("hit and miss counts both moved on one transaction");

endmodule

### sim/set_assoc_cache_tag_lru_fifo_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lru_fifo_unit_tb
// Self-checking bench for the cache tag and replacement engine. A directed
// table covers reset state, eviction under LRU and FIFO and extreme geometry;
// random phases then reprogram the geometry and replay address pools so that
// hits, fills and evictions all occur. Every access is predicted in the bench
// and each result is compared field by field as it strobes out.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lru_fifo_unit_tb;

  localparam int unsigned N_SETS   = 256;
  localparam int unsigned N_WAYS   = 16;
  localparam int unsigned DEPTH    = N_SETS * N_WAYS;
  localparam int unsigned SET_LOG  = 8;
  localparam int unsigned WAY_LOG  = 4;
  localparam int unsigned N_PHASES = 16;
  localparam int unsigned PER_PHASE = 100;
  localparam int unsigned LIMIT    = 600000;

  typedef struct {
    bit       is_cfg;
    logic [sacache_pkg::CFG_IDX_W-1:0]  idx;
    logic [sacache_pkg::CFG_DATA_W-1:0] data;
    sacache_pkg::req_t req;
    bit       typed;
    sacache_pkg::rsp_t exp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [sacache_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [sacache_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic start_i;
  logic busy_o;
  sacache_pkg::req_t req_i;
  logic done_o;
  sacache_pkg::rsp_t rsp_o;

  set_assoc_cache_tag_lru_fifo_unit dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .start_i, .busy_o, .req_i, .done_o, .rsp_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow cache
  sacache_pkg::cfg_t cache_cfg;
  logic [47:0] shadow_tag [DEPTH];
  logic [47:0] shadow_age [DEPTH];
  bit          shadow_vld [DEPTH];
  logic [47:0] shadow_clk;
  sacache_pkg::rsp_t shadow_tot;

  sacache_pkg::rsp_t pending_rsp_q[$];
  row_t  stim_rows[$];
  int    errors = 0;
  int    n_checked = 0;
  int    n_hits = 0;
  int    cycles = 0;
  int    burst_left = 0;

  function automatic sacache_pkg::rsp_t cache_access(sacache_pkg::req_t r);
    int unsigned sb, wb, ob, base, slot, w;
    logic [47:0] addr, tag, set_idx;
    bit hit, empty;
    sacache_pkg::rsp_t o;
    sb = (cache_cfg.set_bits > SET_LOG) ? SET_LOG : cache_cfg.set_bits;
    wb = (cache_cfg.way_bits > WAY_LOG) ? WAY_LOG : cache_cfg.way_bits;
    ob = cache_cfg.offset_bits;
    addr = r.address;
    set_idx = (addr >> ob) & ((48'd1 << sb) - 48'd1);
    tag = (ob + sb >= 48) ? 48'd0 : (addr >> (ob + sb));
    if (shadow_clk != sacache_pkg::STAMP_MAX) shadow_clk++;
    base = 32'(set_idx) * N_WAYS;
    slot = base;
    hit = 1'b0;
    empty = 1'b0;
    for (w = 0; w < (1 << wb); w++) begin
      if (!hit && shadow_vld[base+w] && shadow_tag[base+w] == tag) begin
        hit = 1'b1;
        slot = base + w;
      end
    end
    if (hit) begin
      if (cache_cfg.use_lru) shadow_age[slot] = shadow_clk;
    end else begin
      for (w = 0; w < (1 << wb); w++) begin
        if (!empty && !shadow_vld[base+w]) begin
          empty = 1'b1;
          slot = base + w;
        end
      end
      if (!empty) begin
        slot = base;
        for (w = 1; w < (1 << wb); w++)
          if (shadow_age[base+w] < shadow_age[slot]) slot = base + w;
      end
      shadow_vld[slot] = 1'b1;
      shadow_tag[slot] = tag;
      shadow_age[slot] = shadow_clk;
    end
    if (hit) begin
      if (shadow_tot.hit_total != sacache_pkg::CNT_MAX) shadow_tot.hit_total++;
    end else begin
      if (shadow_tot.miss_total != sacache_pkg::CNT_MAX) shadow_tot.miss_total++;
      if (shadow_tot.read_total != sacache_pkg::CNT_MAX) shadow_tot.read_total++;
    end
    if (r.req_type && shadow_tot.write_total != sacache_pkg::CNT_MAX)
      shadow_tot.write_total++;
    o = shadow_tot;
    o.hit = hit;
    o.mem_read = !hit;
    o.mem_write = r.req_type;
    return o;
  endfunction

  function automatic void check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
    end
  endfunction

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("set_assoc_cache_tag_lru_fifo_unit_tb: done, errors");
      $finish;
    end
    if (rst_ni && done_o) begin
      if (pending_rsp_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, rsp_o);
      end else begin
        sacache_pkg::rsp_t e;
        e = pending_rsp_q.pop_front();
        n_checked++;
        if (rsp_o.hit === 1'b1) n_hits++;
        check_field("hit", 32'(e.hit), 32'(rsp_o.hit));
        check_field("mem_read", 32'(e.mem_read), 32'(rsp_o.mem_read));
        check_field("mem_write", 32'(e.mem_write), 32'(rsp_o.mem_write));
        check_field("read_total", e.read_total, rsp_o.read_total);
        check_field("write_total", e.write_total, rsp_o.write_total);
        check_field("hit_total", e.hit_total, rsp_o.hit_total);
        check_field("miss_total", e.miss_total, rsp_o.miss_total);
      end
    end
  end

  // leaves cfg_valid_i high; the caller drops it after the last write
  task automatic cfg_write(logic [sacache_pkg::CFG_IDX_W-1:0] idx,
                           logic [sacache_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      sacache_pkg::CFG_OFFSET_BITS: cache_cfg.offset_bits = data;
      sacache_pkg::CFG_SET_BITS:    cache_cfg.set_bits    = data[3:0];
      sacache_pkg::CFG_WAY_BITS:    cache_cfg.way_bits    = data[2:0];
      default:                      cache_cfg.use_lru     = data[0];
    endcase
  endtask

  task automatic send(sacache_pkg::req_t r, bit typed, sacache_pkg::rsp_t e);
    sacache_pkg::rsp_t p;
    if (burst_left == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : int'($urandom_range(1, 12));
    end
    burst_left--;
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    p = cache_access(r);
    pending_rsp_q.push_back(typed ? e : p);
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    while (pending_rsp_q.size() != 0 || busy_o) @(posedge clk_i);
  endtask

  function automatic void add_acc(logic t, logic [47:0] a, bit typed = 1'b0,
                                  logic [3:0] flags = 4'd0, logic [31:0] r = 32'd0,
                                  logic [31:0] w = 32'd0, logic [31:0] h = 32'd0,
                                  logic [31:0] m = 32'd0);
    row_t x;
    x = '{default: '0};
    x.req = '{req_type: t, address: a};
    x.typed = typed;
    x.exp = '{hit: flags[2], mem_read: flags[1], mem_write: flags[0],
              read_total: r, write_total: w, hit_total: h, miss_total: m};
    stim_rows.push_back(x);
  endfunction

  function automatic void add_cfg(logic [sacache_pkg::CFG_IDX_W-1:0] idx,
                                  logic [sacache_pkg::CFG_DATA_W-1:0] d);
    row_t x;
    x = '{default: '0};
    x.is_cfg = 1'b1;
    x.idx = idx;
    x.data = d;
    stim_rows.push_back(x);
  endfunction

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  initial begin
    logic [47:0] pool [32];
    logic [47:0] off_mask, a;
    sacache_pkg::rsp_t none;
    row_t x;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    start_i = 1'b0;
    req_i = '0;
    none = '0;
    cache_cfg = '{offset_bits: 5'd4, set_bits: 4'd0, way_bits: 3'd0, use_lru: 1'b1};
    foreach (shadow_vld[i]) shadow_vld[i] = 1'b0;
    shadow_clk = '0;
    shadow_tot = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry is direct mapped, one set
    add_acc(1'b0, 48'h0, 1'b1, 4'b0010, 32'd1, 32'd0, 32'd0, 32'd1);
    add_acc(1'b1, 48'h0, 1'b1, 4'b0101, 32'd1, 32'd1, 32'd1, 32'd1);
    add_acc(1'b0, 48'hFFFF_FFFF_FFFF, 1'b1, 4'b0010, 32'd2, 32'd1, 32'd1, 32'd2);
    add_acc(1'b1, 48'hFFFF_FFFF_FFFF, 1'b1, 4'b0101, 32'd2, 32'd2, 32'd2, 32'd2);
    // two sets of two ways, LRU: evict the least recently used way
    add_cfg(sacache_pkg::CFG_OFFSET_BITS, 5'd0);
    add_cfg(sacache_pkg::CFG_SET_BITS, 5'd1);
    add_cfg(sacache_pkg::CFG_WAY_BITS, 5'd1);
    add_acc(1'b0, 48'h0);
    add_acc(1'b0, 48'h2);
    add_acc(1'b1, 48'h0);
    add_acc(1'b0, 48'h4);
    add_acc(1'b0, 48'h2);
    // FIFO: a hit does not refresh the stamp
    add_cfg(sacache_pkg::CFG_USE_LRU, 5'd0);
    add_acc(1'b0, 48'h6);
    add_acc(1'b1, 48'h6);
    add_acc(1'b0, 48'h8);
    add_acc(1'b0, 48'h6);
    // widest offset, oversized set and way counts clamp
    add_cfg(sacache_pkg::CFG_OFFSET_BITS, 5'd31);
    add_cfg(sacache_pkg::CFG_SET_BITS, 5'd15);
    add_cfg(sacache_pkg::CFG_WAY_BITS, 5'd7);
    add_cfg(sacache_pkg::CFG_USE_LRU, 5'd1);
    add_acc(1'b1, 48'hFFFF_FFFF_FFFF);
    add_acc(1'b0, 48'h0);
    add_acc(1'b0, 48'hFFFF_FFFF_FFFF);
    add_acc(1'b1, 48'h8000_0000_0000);

    for (int i = 0; i < stim_rows.size(); i++) begin
      x = stim_rows[i];
      if (x.is_cfg) begin
        if (i == 0 || !stim_rows[i-1].is_cfg) wait_idle();
        cfg_write(x.idx, x.data);
        if (i + 1 == stim_rows.size() || !stim_rows[i+1].is_cfg) cfg_valid_i <= 1'b0;
      end else begin
        send(x.req, x.typed, x.exp);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      logic [4:0] ob;
      logic [3:0] sb;
      logic [2:0] wb;
      ob = (ph == 0) ? 5'd0 : (ph == 1) ? 5'd31 : 5'($urandom_range(0, 20));
      sb = (ph == 0) ? 4'd0 : (ph == 1) ? 4'd15 : 4'($urandom_range(0, 9));
      wb = (ph == 0) ? 3'd0 : (ph == 1) ? 3'd7 : 3'($urandom_range(0, 5));
      wait_idle();
      cfg_write(sacache_pkg::CFG_OFFSET_BITS, ob);
      cfg_write(sacache_pkg::CFG_SET_BITS, {1'b0, sb});
      cfg_write(sacache_pkg::CFG_WAY_BITS, {2'b0, wb});
      cfg_write(sacache_pkg::CFG_USE_LRU, {4'b0, ph[0]});
      cfg_valid_i <= 1'b0;
      off_mask = (48'd1 << ob) - 48'd1;
      // small pool keeps sets busy enough to hit and evict
      foreach (pool[k]) pool[k] = rand48();
      for (int n = 0; n < PER_PHASE; n++) begin
        if ($urandom_range(0, 3) != 0)
          a = pool[$urandom_range(0, 5 + ph)] ^ (rand48() & off_mask);
        else
          a = rand48();
        send('{req_type: 1'($urandom_range(0, 1)), address: a}, 1'b0, none);
      end
    end

    wait_idle();
    repeat (30) @(posedge clk_i);
    $display("checked %0d results (%0d hits) over %0d geometry phases plus directed rows",
             n_checked, n_hits, N_PHASES);
    if (errors == 0 && pending_rsp_q.size() == 0)
      $display("set_assoc_cache_tag_lru_fifo_unit_tb: done, clean");
    else
      $display("set_assoc_cache_tag_lru_fifo_unit_tb: done, errors");
    $finish;
  end

endmodule

### sim.f
src/sacache_pkg.sv
src/sacache_ram.sv
src/sacache_ctrl.sv
src/sacache_dp.sv
src/set_assoc_cache_tag_lru_fifo_unit.sv
sim/set_assoc_cache_tag_lru_fifo_unit_tb.sv
